// File: rtl/core/crtt_pkg.sv
// Package for the character-range transition table: sizes, types and codes.
`timescale 1ns / 1ps
`default_nettype none

package crtt_pkg;

    // Table sizing
    localparam int TABLE_DEPTH   = 64;
    localparam int CHAR_BITS     = 32;
    localparam int STATE_ID_BITS = 16;

    localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

    // Fixed port widths
    localparam int PORT_CHAR_BITS  = 32;
    localparam int PORT_STATE_BITS = 16;
    localparam int SLOT_BITS       = 6;

    // Result reduction: cells are ORed in registered groups
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_e;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_OUT
    } state_e;

    typedef struct packed
    {
        logic [CHAR_BITS-1:0]     low;
        logic [CHAR_BITS-1:0]     high;
        logic [STATE_ID_BITS-1:0] src;
        logic [STATE_ID_BITS-1:0] tgt;
    } entry_t;

    // What one cell offers to the result: zero unless it is the selected cell
    typedef struct packed
    {
        logic                hit;
        logic [IDX_BITS-1:0] slot;
        entry_t              entry;
    } contrib_t;

    // Per-item control from the sequencer to the cells
    typedef struct packed
    {
        logic cmp_en;
        logic shift_en;
        logic is_lookup;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/char_range_transition_table.sv
// Top level of the character-range transition table: sequencer, cell chain, result.
`timescale 1ns / 1ps
`default_nettype none

// Sorted table of up to 64 character-range transitions held in a row of cells,
// each cell one entry. Each transaction runs in turn through acceptance into the
// item register, a compare of the key against all cells at once, a registered
// OR over groups of eight cells, and the final OR into the output register, in
// which cycle an insert also shifts the cells past its slot by one place. A
// result stalled at the output holds the sequencer in its last step; the next
// transaction may be accepted while a finished result still waits. The table is
// empty after reset with no clearing pass; entries beyond the fill count are
// never selected. A full table drops an insert and reports overflow.
module char_range_transition_table
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [31:0] char_a,
    input  wire logic [31:0] char_b,
    input  wire logic [15:0] source_state,
    input  wire logic [15:0] target_state,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic             overflow,
    output logic [5:0]       slot,
    output logic [31:0]      found_low,
    output logic [31:0]      found_high,
    output logic [15:0]      found_source,
    output logic [15:0]      found_target
);
    import crtt_pkg::*;

    state_e state_reg;
    state_e state_next;

    // Item register
    cmd_e                     cmd_reg;
    cmd_e                     cmd_next;
    logic [CHAR_BITS-1:0]     key_reg;
    logic [CHAR_BITS-1:0]     key_next;
    logic [CHAR_BITS-1:0]     hi_reg;
    logic [CHAR_BITS-1:0]     hi_next;
    logic [STATE_ID_BITS-1:0] src_reg;
    logic [STATE_ID_BITS-1:0] src_next;
    logic [STATE_ID_BITS-1:0] tgt_reg;
    logic [STATE_ID_BITS-1:0] tgt_next;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    // Output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic                       overflow_reg;
    logic                       overflow_next;
    logic [SLOT_BITS-1:0]       slot_reg;
    logic [SLOT_BITS-1:0]       slot_next;
    entry_t                     found_reg;
    entry_t                     found_next;

    logic       in_accept;
    logic       out_free;
    logic       full;
    logic       load_sel;
    logic       finish;
    cell_ctrl_t ctrl;

    logic [CHAR_BITS-1:0] a_in;
    logic [CHAR_BITS-1:0] b_in;
    entry_t               new_entry;
    entry_t               cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_ge;
    contrib_t             cell_contrib [TABLE_DEPTH];
    contrib_t             groups [NUM_GROUPS];
    contrib_t             result;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = (count_reg == CNT_BITS'(TABLE_DEPTH));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall       = 1'b1;
        ctrl.cmp_en    = 1'b0;
        ctrl.shift_en  = 1'b0;
        ctrl.is_lookup = (cmd_reg == CMD_LOOKUP);
        load_sel       = 1'b0;
        finish         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_CMP:
            begin
                ctrl.cmp_en = 1'b1;
            end
            S_SEL:
            begin
                load_sel = 1'b1;
            end
            S_OUT:
            begin
                finish        = out_free;
                ctrl.shift_en = out_free && (cmd_reg == CMD_INSERT) && !full;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Item capture: bounds put in order on insert
    assign a_in = CHAR_BITS'(char_a);
    assign b_in = CHAR_BITS'(char_b);

    always_comb
    begin
        cmd_next = cmd_reg;
        key_next = key_reg;
        hi_next  = hi_reg;
        src_next = src_reg;
        tgt_next = tgt_reg;
        if (in_accept)
        begin
            cmd_next = cmd_e'(command);
            src_next = STATE_ID_BITS'(source_state);
            tgt_next = STATE_ID_BITS'(target_state);
            if (cmd_e'(command) == CMD_LOOKUP)
            begin
                key_next = a_in;
                hi_next  = a_in;
            end
            else
            begin
                key_next = (a_in < b_in) ? a_in : b_in;
                hi_next  = (a_in < b_in) ? b_in : a_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        hi_reg  <= hi_next;
        src_reg <= src_next;
        tgt_reg <= tgt_next;
    end

    assign new_entry.low  = key_reg;
    assign new_entry.high = hi_reg;
    assign new_entry.src  = src_reg;
    assign new_entry.tgt  = tgt_reg;

    // Chain of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_ge;
        logic   next_ge;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_ge    = 1'b1;
        end
        else
        begin : g_inner
            assign prev_entry = cell_entry[i - 1];
            assign prev_ge    = cell_ge[i - 1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign next_ge = 1'b0;
        end
        else
        begin : g_body
            assign next_ge = cell_ge[i + 1];
        end

        crtt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .index      (IDX_BITS'(i)),
            .count      (count_reg),
            .key        (key_reg),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .prev_ge    (prev_ge),
            .next_ge    (next_ge),
            .entry      (cell_entry[i]),
            .ge         (cell_ge[i]),
            .contrib    (cell_contrib[i])
        );
    end

    crtt_reduce u_reduce
    (
        .clk      (clk),
        .load     (load_sel),
        .contribs (cell_contrib),
        .groups   (groups)
    );

    // Final OR across the groups
    always_comb
    begin
        logic [$bits(contrib_t)-1:0] acc;
        acc = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            acc = acc | groups[g];
        end
        result = contrib_t'(acc);
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.shift_en)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    // Result formation
    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        overflow_next  = overflow_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
            priority if (cmd_reg == CMD_LOOKUP)
            begin
                hit_next      = result.hit;
                overflow_next = 1'b0;
                slot_next     = SLOT_BITS'(result.slot);
                found_next    = result.entry;
            end
            else if (full)
            begin
                hit_next      = 1'b0;
                overflow_next = 1'b1;
                slot_next     = '0;
                found_next    = '0;
            end
            else
            begin
                hit_next      = 1'b1;
                overflow_next = 1'b0;
                slot_next     = SLOT_BITS'(result.slot);
                found_next    = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        overflow_reg <= overflow_next;
        slot_reg     <= slot_next;
        found_reg    <= found_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign overflow     = overflow_reg;
    assign slot         = slot_reg;
    assign found_low    = PORT_CHAR_BITS'(found_reg.low);
    assign found_high   = PORT_CHAR_BITS'(found_reg.high);
    assign found_source = PORT_STATE_BITS'(found_reg.src);
    assign found_target = PORT_STATE_BITS'(found_reg.tgt);

endmodule

`default_nettype wire

// File: rtl/core/crtt_cell.sv
// One table cell: holds an entry, compares it with the key and shifts on insert.
`timescale 1ns / 1ps
`default_nettype none

module crtt_cell
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [crtt_pkg::IDX_BITS-1:0]     index,
    input  wire logic [crtt_pkg::CNT_BITS-1:0]     count,
    input  wire logic [crtt_pkg::CHAR_BITS-1:0]    key,
    input  wire crtt_pkg::cell_ctrl_t              ctrl,
    input  wire crtt_pkg::entry_t                  new_entry,
    input  wire crtt_pkg::entry_t                  prev_entry,
    input  wire logic                              prev_ge,
    input  wire logic                              next_ge,
    output crtt_pkg::entry_t                       entry,
    output logic                                   ge,
    output crtt_pkg::contrib_t                     contrib
);
    import crtt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   ge_reg;
    logic   ge_next;
    logic   valid;
    logic   mark;
    logic   covered;

    // Entry is live when its position is below the fill count
    assign valid = (CNT_BITS'(index) < count);

    // Compare flag: live entry whose low bound is not above the key
    always_comb
    begin
        ge_next = ge_reg;
        if (ctrl.cmp_en)
        begin
            ge_next = valid && (key >= entry_reg.low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
        end
        else
        begin
            ge_reg <= ge_next;
        end
    end

    // Selection: last ge cell for lookup, first non-ge cell for insert
    assign covered = (key <= entry_reg.high);
    assign mark    = ctrl.is_lookup ? (ge_reg && !next_ge) : (!ge_reg && prev_ge);

    always_comb
    begin
        contrib = '0;
        if (ctrl.is_lookup)
        begin
            if (mark && covered)
            begin
                contrib.hit   = 1'b1;
                contrib.slot  = index;
                contrib.entry = entry_reg;
            end
        end
        else if (mark)
        begin
            contrib.hit  = 1'b1;
            contrib.slot = index;
        end
    end

    // Insert: cells past the slot take their neighbour's entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_en && !ge_reg)
        begin
            entry_next = prev_ge ? new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;

endmodule

`default_nettype wire

// File: rtl/core/crtt_reduce.sv
// Registered first level of the result OR tree: one OR per group of cells.
`timescale 1ns / 1ps
`default_nettype none

module crtt_reduce
(
    input  wire logic                clk,
    input  wire logic                load,
    input  wire crtt_pkg::contrib_t  contribs [crtt_pkg::TABLE_DEPTH],
    output crtt_pkg::contrib_t       groups   [crtt_pkg::NUM_GROUPS]
);
    import crtt_pkg::*;

    contrib_t groups_reg  [NUM_GROUPS];
    contrib_t groups_next [NUM_GROUPS];

    // OR the cells of each group; at most one cell is non-zero overall
    always_comb
    begin
        logic [$bits(contrib_t)-1:0] acc;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            acc = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < TABLE_DEPTH)
                begin
                    acc = acc | contribs[g * GROUP_SIZE + j];
                end
            end
            groups_next[g] = load ? contrib_t'(acc) : groups_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            groups_reg[g] <= groups_next[g];
        end
    end

    assign groups = groups_reg;

endmodule

`default_nettype wire
